// ----- rtl/ssa_pkg.sv -----
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared constants, codes and transfer types of the swap slot allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

  // sizing
  localparam int MAX_SLOTS        = 1024;
  localparam int SECTORS_PER_SLOT = 8;

  // fixed field widths
  localparam int CFG_W    = 11;
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 10;
  localparam int SECTOR_W = 13;
  localparam int STATUS_W = 2;

  // free map organisation: rows of ROW_W slot bits
  localparam int ROW_W  = 32;
  localparam int COL_AW = $clog2(ROW_W);
  localparam int ROWS   = (MAX_SLOTS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = $clog2(ROWS);
  localparam int ROW_CW = $clog2(ROWS + 1);
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int OFS_W  = $clog2(SECTORS_PER_SLOT + 1);

  localparam int SLOT_COUNT_RESET = 1024;
  localparam int COUNT_RESET      = (MAX_SLOTS < SLOT_COUNT_RESET) ? MAX_SLOTS
                                                                   : SLOT_COUNT_RESET;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SWAP_IN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE    = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot_index;
  } ssa_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] sector;
    logic                last;
    logic [STATUS_W-1:0] status;
  } ssa_out_t;

  // sequencer to free map
  typedef struct packed {
    logic              rd_en;
    logic [ROW_AW-1:0] rd_row;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_row;
    logic [ROW_W-1:0]  wr_data;
  } map_req_t;

  // free map to sequencer
  typedef struct packed {
    logic [ROW_W-1:0] row_data;
    logic [ROWS-1:0]  row_avail;
  } map_rsp_t;

endpackage

// ----- rtl/ssa_ram.sv -----
// ----------------------------------------------------------------------------
// ssa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/ssa_map.sv -----
// ----------------------------------------------------------------------------
// ssa_map
// Slot free map: row RAM plus per-row written and has-free flags.
// ----------------------------------------------------------------------------
module ssa_map
  import ssa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  map_req_t req,
  output map_rsp_t rsp
);

  logic [ROWS-1:0]  row_vld_r;
  logic [ROWS-1:0]  row_free_r;
  logic             rd_vld_r;
  logic [ROW_W-1:0] ram_q;

  ssa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_row),
    .wr_data (req.wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_row),
    .rd_data (ram_q)
  );

  // a row never written reads back as all ones: every slot free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r  <= '0;
      row_free_r <= '1;
    end else if (req.wr_en) begin
      row_vld_r[req.wr_row]  <= 1'b1;
      row_free_r[req.wr_row] <= |req.wr_data;
    end
    if (req.rd_en) begin
      rd_vld_r <= row_vld_r[req.rd_row];
    end
  end

  assign rsp.row_data  = rd_vld_r ? ram_q : '1;
  assign rsp.row_avail = row_free_r;

endmodule

// ----- rtl/ssa_seq.sv -----
// ----------------------------------------------------------------------------
// ssa_seq
// Request sequencer: map lookup, update and sector burst generation.
// ----------------------------------------------------------------------------
module ssa_seq
  import ssa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ssa_in_t          in_data,
  input  logic [CNT_W-1:0] count,
  output map_req_t         map_req,
  input  map_rsp_t         map_rsp,
  output logic             out_valid,
  input  logic             out_stall,
  output ssa_out_t         out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_ROW,
    S_EMIT,
    S_REPORT
  } state_t;

  state_t               state_r, state_nxt;
  logic [KIND_W-1:0]    kind_r, kind_nxt;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic [ROW_AW-1:0]    row_r, row_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [SECTOR_W-1:0]  sector_r, sector_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [OFS_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ssa_out_t             out_data_r, out_data_nxt;

  logic                 out_ok;
  logic                 emit_last;
  logic [ROW_CW-1:0]    row_lim;
  logic [ROW_CW-1:0]    full_rows;
  logic [ROWS-1:0]      rows_ok;
  logic [ROWS-1:0]      avail;
  logic                 row_hit;
  logic [ROW_AW-1:0]    row_first;
  logic [ROW_W-1:0]     col_mask;
  logic [ROW_W-1:0]     cand;
  logic                 col_hit;
  logic [COL_AW-1:0]    col_first;
  logic [COL_AW-1:0]    idx_col;
  logic [ROW_AW-1:0]    idx_row;
  logic                 idx_beyond;
  logic [SLOT_W-1:0]    alloc_slot;

  assign out_ok    = !out_valid_r || !out_stall;
  assign emit_last = (cnt_r == OFS_W'(SECTORS_PER_SLOT - 1));
  assign idx_col   = idx_r[COL_AW-1:0];
  assign idx_row   = idx_r[SLOT_W-1:COL_AW];
  assign idx_beyond = (CNT_W'(idx_r) >= count);
  assign alloc_slot = {row_r, col_first};

  // rows that hold at least one slot below the count
  assign row_lim   = ROW_CW'(({1'b0, count} + (CNT_W + 1)'(ROW_W - 1)) >> COL_AW);
  assign full_rows = ROW_CW'(count >> COL_AW);

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      rows_ok[r] = (ROW_CW'(r) < row_lim);
    end
  end

  assign avail   = map_rsp.row_avail & rows_ok;
  assign row_hit = |avail;

  always_comb begin
    row_first = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (avail[r]) begin
        row_first = ROW_AW'(r);
      end
    end
  end

  // slots of the current row that lie below the count
  always_comb begin
    if (ROW_CW'(row_r) < full_rows) begin
      col_mask = '1;
    end else if (ROW_CW'(row_r) == full_rows) begin
      col_mask = (ROW_W'(1) << count[COL_AW-1:0]) - ROW_W'(1);
    end else begin
      col_mask = '0;
    end
  end

  assign cand    = map_rsp.row_data & col_mask;
  assign col_hit = |cand;

  always_comb begin
    col_first = '0;
    for (int c = ROW_W - 1; c >= 0; c--) begin
      if (cand[c]) begin
        col_first = COL_AW'(c);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    row_nxt       = row_r;
    slot_nxt      = slot_r;
    sector_nxt    = sector_r;
    status_nxt    = status_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    map_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_data.kind;
          idx_nxt   = in_data.slot_index;
          state_nxt = S_LOOK;
        end
      end

      S_LOOK: begin
        case (kind_r)
          KIND_ALLOC: begin
            if (row_hit) begin
              row_nxt        = row_first;
              map_req.rd_en  = 1'b1;
              map_req.rd_row = row_first;
              state_nxt      = S_ROW;
            end else begin
              slot_nxt   = '0;
              sector_nxt = '0;
              status_nxt = ST_NO_FREE;
              state_nxt  = S_REPORT;
            end
          end
          KIND_SWAP_IN, KIND_FREE: begin
            if (idx_beyond) begin
              slot_nxt   = idx_r;
              sector_nxt = '0;
              status_nxt = ST_RANGE;
              state_nxt  = S_REPORT;
            end else begin
              row_nxt        = idx_row;
              map_req.rd_en  = 1'b1;
              map_req.rd_row = idx_row;
              state_nxt      = S_ROW;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_ROW: begin
        if (kind_r == KIND_ALLOC) begin
          if (col_hit) begin
            map_req.wr_en   = 1'b1;
            map_req.wr_row  = row_r;
            map_req.wr_data = map_rsp.row_data & ~(ROW_W'(1) << col_first);
            slot_nxt        = alloc_slot;
            sector_nxt      = SECTOR_W'(SECTOR_W'(alloc_slot) * SECTOR_W'(SECTORS_PER_SLOT));
            cnt_nxt         = '0;
            state_nxt       = S_EMIT;
          end else begin
            slot_nxt   = '0;
            sector_nxt = '0;
            status_nxt = ST_NO_FREE;
            state_nxt  = S_REPORT;
          end
        end else if (map_rsp.row_data[idx_col]) begin
          slot_nxt   = idx_r;
          sector_nxt = '0;
          status_nxt = ST_NOT_USED;
          state_nxt  = S_REPORT;
        end else begin
          map_req.wr_en   = 1'b1;
          map_req.wr_row  = row_r;
          map_req.wr_data = map_rsp.row_data | (ROW_W'(1) << idx_col);
          slot_nxt        = idx_r;
          if (kind_r == KIND_SWAP_IN) begin
            sector_nxt = SECTOR_W'(SECTOR_W'(idx_r) * SECTOR_W'(SECTORS_PER_SLOT));
            cnt_nxt    = '0;
            state_nxt  = S_EMIT;
          end else begin
            sector_nxt = '0;
            status_nxt = ST_OK;
            state_nxt  = S_REPORT;
          end
        end
      end

      S_EMIT: begin
        if (out_ok) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.slot   = slot_r;
          out_data_nxt.sector = sector_r;
          out_data_nxt.last   = emit_last;
          out_data_nxt.status = ST_OK;
          sector_nxt          = sector_r + 1'b1;
          cnt_nxt             = cnt_r + 1'b1;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_REPORT: begin
        if (out_ok) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.slot   = slot_r;
          out_data_nxt.sector = sector_r;
          out_data_nxt.last   = 1'b1;
          out_data_nxt.status = status_r;
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    idx_r      <= idx_nxt;
    row_r      <= row_nxt;
    slot_r     <= slot_nxt;
    sector_r   <= sector_nxt;
    status_r   <= status_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/swap_slot_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// swap_slot_allocator_unit
// First-fit swap slot allocator over a bitmap of free slots.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request is taken in the idle state,
// then the look-up state finds the first row with a free slot (or checks the
// range), and the row state reads the free map row and writes back any change.
// Allocate and swap-in then stream SECTORS_PER_SLOT sector numbers, one per
// cycle while the output is not stalled, through the single output register.
// Free, a slot not in use and a full map found in the row read give their one
// result after the row state; a slot beyond the count and a map with no free
// row below the count give it straight after the look-up state, and an
// undefined kind gives no result. The free map is a RAM of 32-slot rows with
// a flop per row for "written" and "has a free slot", so it needs no clearing
// pass after reset. The user must write the slot count only while the block is
// idle; the block does not enforce it. Values above MAX_SLOTS are saturated.
module swap_slot_allocator_unit
  import ssa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ssa_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ssa_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  logic [CNT_W-1:0] count_r, count_nxt;
  map_req_t         map_req;
  map_rsp_t         map_rsp;

  // saturate the written slot count to the map size
  always_comb begin
    if (int'(cfg_wr_data) > MAX_SLOTS) begin
      count_nxt = CNT_W'(MAX_SLOTS);
    end else begin
      count_nxt = CNT_W'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(COUNT_RESET);
    end else if (cfg_wr_en) begin
      count_r <= count_nxt;
    end
  end

  ssa_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .count     (count_r),
    .map_req   (map_req),
    .map_rsp   (map_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ssa_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (map_req),
    .rsp   (map_rsp)
  );

endmodule

// ----- rtl/ssa_checker.sv -----
// ----------------------------------------------------------------------------
// ssa_checker
// Port-level checks of the swap slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ssa_checker
  import ssa_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input ssa_out_t         out_data
);

  // reset leaves the block ready with nothing to deliver
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // a request keeps the block busy for at least the following cycle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after a transfer");

  // within a sector burst the next result follows at once, same slot, next sector
  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=>
      out_valid && out_data.slot == $past(out_data.slot) &&
      out_data.sector == SECTOR_W'($past(out_data.sector) + 1'b1))
    else $error("sector burst broken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind swap_slot_allocator_unit ssa_checker u_ssa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_data    (out_data)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the swap slot allocator: a stimulus table of edge
// cases, then random allocate, swap-in and free traffic at several slot
// counts, with results compared against a free-map predictor in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import ssa_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNDEF = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_CAP     = 100;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_e;

  typedef struct packed {
    row_op_e             op;
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot_index;
    logic [CFG_W-1:0]    cfg_value;
    logic                typed;
    ssa_out_t            exp;
  } dir_row_t;

  localparam ssa_out_t NONE = '0;

  // rows with typed set carry the one result the request must give
  localparam dir_row_t DIR_TABLE [28] = '{
    '{ROW_ITEM, KIND_FREE,    10'd0,    11'd0,    1'b1, '{10'd0, 13'd0, 1'b1, ST_NOT_USED}},
    '{ROW_ITEM, KIND_SWAP_IN, 10'd1023, 11'd0,    1'b1, '{10'd1023, 13'd0, 1'b1, ST_NOT_USED}},
    '{ROW_ITEM, KIND_ALLOC,   10'd1023, 11'd0,    1'b0, NONE},
    '{ROW_ITEM, KIND_ALLOC,   10'd0,    11'd0,    1'b0, NONE},
    '{ROW_ITEM, KIND_SWAP_IN, 10'd0,    11'd0,    1'b0, NONE},
    '{ROW_ITEM, KIND_FREE,    10'd1,    11'd0,    1'b1, '{10'd1, 13'd0, 1'b1, ST_OK}},
    '{ROW_ITEM, KIND_UNDEF,   10'd1023, 11'd0,    1'b0, NONE},
    '{ROW_ITEM, KIND_ALLOC,   10'd0,    11'd0,    1'b0, NONE},
    '{ROW_ITEM, KIND_FREE,    10'd0,    11'd0,    1'b1, '{10'd0, 13'd0, 1'b1, ST_OK}},
    '{ROW_CFG,  KIND_ALLOC,   10'd0,    11'd1,    1'b0, NONE},
    '{ROW_ITEM, KIND_ALLOC,   10'd0,    11'd0,    1'b0, NONE},
    '{ROW_ITEM, KIND_ALLOC,   10'd0,    11'd0,    1'b1, '{10'd0, 13'd0, 1'b1, ST_NO_FREE}},
    '{ROW_ITEM, KIND_FREE,    10'd1,    11'd0,    1'b1, '{10'd1, 13'd0, 1'b1, ST_RANGE}},
    '{ROW_ITEM, KIND_SWAP_IN, 10'd1023, 11'd0,    1'b1, '{10'd1023, 13'd0, 1'b1, ST_RANGE}},
    '{ROW_ITEM, KIND_SWAP_IN, 10'd0,    11'd0,    1'b0, NONE},
    '{ROW_CFG,  KIND_ALLOC,   10'd0,    11'd0,    1'b0, NONE},
    '{ROW_ITEM, KIND_ALLOC,   10'd0,    11'd0,    1'b1, '{10'd0, 13'd0, 1'b1, ST_NO_FREE}},
    '{ROW_ITEM, KIND_FREE,    10'd0,    11'd0,    1'b1, '{10'd0, 13'd0, 1'b1, ST_RANGE}},
    '{ROW_ITEM, KIND_UNDEF,   10'd0,    11'd0,    1'b0, NONE},
    '{ROW_CFG,  KIND_ALLOC,   10'd0,    11'd2047, 1'b0, NONE},
    '{ROW_ITEM, KIND_ALLOC,   10'd512,  11'd0,    1'b0, NONE},
    '{ROW_ITEM, KIND_FREE,    10'd1023, 11'd0,    1'b1, '{10'd1023, 13'd0, 1'b1, ST_NOT_USED}},
    '{ROW_ITEM, KIND_ALLOC,   10'd0,    11'd0,    1'b0, NONE},
    '{ROW_CFG,  KIND_ALLOC,   10'd0,    11'd2,    1'b0, NONE},
    '{ROW_ITEM, KIND_ALLOC,   10'd0,    11'd0,    1'b1, '{10'd0, 13'd0, 1'b1, ST_NO_FREE}},
    '{ROW_ITEM, KIND_SWAP_IN, 10'd1,    11'd0,    1'b0, NONE},
    '{ROW_ITEM, KIND_FREE,    10'd2,    11'd0,    1'b1, '{10'd2, 13'd0, 1'b1, ST_RANGE}},
    '{ROW_ITEM, KIND_FREE,    10'd0,    11'd0,    1'b1, '{10'd0, 13'd0, 1'b1, ST_OK}}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  ssa_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  ssa_out_t         out_data;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  // free-map predictor state
  bit               free_map_model [MAX_SLOTS];
  logic [CFG_W-1:0] slot_count_model;
  ssa_out_t         pending_results [$];

  bit               typed_active;
  ssa_out_t         typed_result;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      mismatch_count;
  int unsigned      requests_taken;
  int unsigned      results_checked;
  int unsigned      cycle_count;

  swap_slot_allocator_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic int unsigned effective_slot_count();
    return (slot_count_model > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count_model);
  endfunction

  function automatic void push_sector_run(input int unsigned s, input bit keep);
    ssa_out_t res;
    for (int i = 0; i < SECTORS_PER_SLOT; i++) begin
      res.slot   = SLOT_W'(s);
      res.sector = SECTOR_W'(s * SECTORS_PER_SLOT + i);
      res.last   = (i == SECTORS_PER_SLOT - 1);
      res.status = ST_OK;
      if (keep) pending_results.push_back(res);
    end
  endfunction

  // updates the free map and, when keep is set, queues the expected transfers
  function automatic void predict_slot_results(input ssa_in_t req, input bit keep);
    int unsigned lim;
    int          found;
    ssa_out_t    res;
    lim   = effective_slot_count();
    found = -1;
    res   = '0;
    res.last = 1'b1;
    if (req.kind == KIND_ALLOC) begin
      for (int i = 0; i < lim; i++) begin
        if (free_map_model[i] && found < 0) found = i;
      end
      if (found >= 0) begin
        free_map_model[found] = 1'b0;
        push_sector_run(found, keep);
      end else begin
        res.status = ST_NO_FREE;
        if (keep) pending_results.push_back(res);
      end
    end else if (req.kind == KIND_SWAP_IN || req.kind == KIND_FREE) begin
      res.slot = req.slot_index;
      if (req.slot_index >= lim) begin
        res.status = ST_RANGE;
        if (keep) pending_results.push_back(res);
      end else if (free_map_model[req.slot_index]) begin
        res.status = ST_NOT_USED;
        if (keep) pending_results.push_back(res);
      end else begin
        free_map_model[req.slot_index] = 1'b1;
        if (req.kind == KIND_SWAP_IN) begin
          push_sector_run(req.slot_index, keep);
        end else begin
          res.status = ST_OK;
          if (keep) pending_results.push_back(res);
        end
      end
    end
  endfunction

  // mostly well-formed traffic: swap-ins and frees favour slots in use
  function automatic ssa_in_t random_request();
    int unsigned roll;
    int unsigned lim;
    int unsigned used_slots [$];
    ssa_in_t     req;
    lim  = effective_slot_count();
    roll = $urandom_range(99);
    req.slot_index = SLOT_W'($urandom_range(MAX_SLOTS - 1));
    if (roll < 8) begin
      req.kind = KIND_UNDEF;
    end else if (roll < 48) begin
      req.kind = KIND_ALLOC;
    end else begin
      req.kind = ($urandom_range(1) == 0) ? KIND_SWAP_IN : KIND_FREE;
      for (int i = 0; i < lim; i++) begin
        if (!free_map_model[i]) used_slots.push_back(i);
      end
      roll = $urandom_range(99);
      if (roll < 70 && used_slots.size() > 0) begin
        req.slot_index = SLOT_W'(used_slots[$urandom_range(used_slots.size() - 1)]);
      end else if (roll < 85 && lim < MAX_SLOTS) begin
        req.slot_index = SLOT_W'(lim + $urandom_range(3));
      end
    end
    return req;
  endfunction

  task automatic log_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_result(input ssa_out_t got);
    ssa_out_t want;
    if (pending_results.size() == 0) begin
      log_mismatch($sformatf("unexpected transfer slot %0d sector %0d status %0d",
                             got.slot, got.sector, got.status));
    end else begin
      want = pending_results.pop_front();
      if (got.slot !== want.slot)
        log_mismatch($sformatf("slot %0d, wanted %0d", got.slot, want.slot));
      if (got.sector !== want.sector)
        log_mismatch($sformatf("sector %0d, wanted %0d", got.sector, want.sector));
      if (got.last !== want.last)
        log_mismatch($sformatf("last %0b, wanted %0b", got.last, want.last));
      if (got.status !== want.status)
        log_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
      results_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_slot_results(in_data, !typed_active);
      if (typed_active) pending_results.push_back(typed_result);
      if (in_data.kind != KIND_UNDEF) requests_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  // called and left at a falling edge with in_valid low
  task automatic drive_item(input ssa_in_t req, input bit typed, input ssa_out_t exp);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid     <= 1'b1;
    in_data      <= req;
    typed_active = typed;
    typed_result = exp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_slot_count(input logic [CFG_W-1:0] value);
    wait_drained();
    // a request with no result may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    slot_count_model = value;
  endtask

  task automatic run_random_phase(input int unsigned sender_pct, input int unsigned recv_pct,
                                  input logic [CFG_W-1:0] count, input int unsigned n);
    int unsigned done;
    ssa_in_t     req;
    write_slot_count(count);
    send_idle_pct = sender_pct;
    recv_idle_pct = recv_pct;
    done = 0;
    while (done < n) begin
      req = random_request();
      drive_item(req, 1'b0, NONE);
      done++;
      if ($urandom_range(49) == 0) wait_drained();
    end
  endtask

  initial begin
    ssa_in_t req;
    for (int i = 0; i < MAX_SLOTS; i++) free_map_model[i] = 1'b1;
    slot_count_model = CFG_W'(SLOT_COUNT_RESET);
    send_idle_pct = 19;
    recv_idle_pct = 82;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].op == ROW_CFG) begin
        write_slot_count(DIR_TABLE[i].cfg_value);
      end else begin
        req.kind       = DIR_TABLE[i].kind;
        req.slot_index = DIR_TABLE[i].slot_index;
        drive_item(req, DIR_TABLE[i].typed, DIR_TABLE[i].exp);
      end
    end

    run_random_phase(19, 82, CFG_W'($urandom_range(33, 96)), 118);
    run_random_phase(82, 19, CFG_W'(MAX_SLOTS), 117);
    run_random_phase(0, 0, CFG_W'($urandom_range(1, 12)), 117);

    wait_drained();
    repeat (20) @(negedge clk);

    $display("covered %0d requests and %0d checked transfers, %0d mismatches",
             requests_taken, results_checked, mismatch_count);
    $display("slot counts 0, 1, 2, 2047, 1024 and random, with and without stalls");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
